// ----- sv/shcc_pkg.sv -----
// shared types, constants and crc function for the state block header crc checker
`default_nettype none

package shcc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1048576;
  localparam int unsigned HDR_BYTES       = 20;
  localparam int unsigned OFFSET_W        = 5;
  localparam int unsigned LEN_W           = 21;

  localparam logic [31:0] CRC_POLY        = 32'hedb88320;
  localparam logic [31:0] CRC_INIT        = 32'hffffffff;
  localparam logic [7:0]  FORMAT_VERSION  = 8'd1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } shcc_status_e;

  typedef struct packed {
    logic                valid;
    shcc_status_e        status;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } shcc_res_t;

  // magic bytes of the header, in stream order
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h54;
      2'd1:    b = 8'h4d;
      2'd2:    b = 8'h52;
      default: b = 8'h41;
    endcase
    return b;
  endfunction

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/shcc_in_if.sv -----
// input channel: one block byte per request
`default_nettype none

interface shcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       empty_block;

  modport source (output valid, output byte_value, output last_byte, output empty_block,
                  input ready);
  modport sink   (input valid, input byte_value, input last_byte, input empty_block,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/shcc_out_if.sv -----
// output channel: one check result per request
`default_nettype none

interface shcc_out_if;
  import shcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [OFFSET_W-1:0] payload_offset;
  logic [LEN_W-1:0]    payload_length;

  modport source (output valid, output status, output payload_offset, output payload_length,
                  input ready);
  modport sink   (input valid, input status, input payload_offset, input payload_length,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/shcc_core.sv -----
// block state, header check, crc update and end-of-block decision
`default_nettype none

module shcc_core #(
  parameter int unsigned MAX_PAYLOAD = shcc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_value_i,
  input  wire logic             last_byte_i,
  input  wire logic             empty_block_i,
  output shcc_pkg::shcc_res_t   res_o
);
  import shcc_pkg::*;

  // counter saturates above any length that can still pass
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + HDR_BYTES + 2);
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_HDR = CW'(HDR_BYTES);

  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   crc_q, crc_d;
  logic          bad_q, bad_d;
  logic [31:0]   len_q, len_d;
  logic [31:0]   chk_q, chk_d;
  logic [4:0]    sh;
  logic [CW-1:0] pay_cnt;
  logic          ok;
  logic          done;

  always_comb begin
    sh    = {cnt_q[1:0], 3'b000};
    bad_d = bad_q;
    len_d = len_q;
    chk_d = chk_q;
    crc_d = crc_q;
    if (cnt_q < CW'(4)) begin
      if (byte_value_i != magic_byte(cnt_q[1:0])) bad_d = 1'b1;
    end else if (cnt_q < CW'(8)) begin
      if (byte_value_i != ((cnt_q[1:0] == 2'd0) ? FORMAT_VERSION : 8'd0)) bad_d = 1'b1;
    end else if (cnt_q < CW'(12)) begin
      if (byte_value_i != 8'd0) bad_d = 1'b1;
    end else if (cnt_q < CW'(16)) begin
      len_d = len_q | ({24'd0, byte_value_i} << sh);
    end else if (cnt_q < CNT_HDR) begin
      chk_d = chk_q | ({24'd0, byte_value_i} << sh);
    end else begin
      crc_d = crc_byte(crc_q, byte_value_i);
    end
    cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CW'(1);
  end

  // end-of-block decision on the updated state
  always_comb begin
    pay_cnt = cnt_d - CNT_HDR;
    ok = !bad_d
      && (cnt_d >= CNT_HDR)
      && (len_d != 32'd0)
      && (len_d <= 32'(MAX_PAYLOAD))
      && (len_d == 32'(pay_cnt))
      && ((crc_d ^ CRC_INIT) == chk_d);
    done = empty_block_i || last_byte_i;

    res_o.valid = done;
    if (empty_block_i) begin
      res_o.status = ST_EMPTY;
      res_o.offset = '0;
      res_o.length = '0;
    end else if (ok) begin
      res_o.status = ST_VALID;
      res_o.offset = OFFSET_W'(HDR_BYTES);
      res_o.length = len_d[LEN_W-1:0];
    end else begin
      res_o.status = ST_INVALID;
      res_o.offset = '0;
      res_o.length = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= CRC_INIT;
      bad_q <= 1'b0;
      len_q <= '0;
      chk_q <= '0;
    end else if (step_i) begin
      if (done) begin
        cnt_q <= '0;
        crc_q <= CRC_INIT;
        bad_q <= 1'b0;
        len_q <= '0;
        chk_q <= '0;
      end else begin
        cnt_q <= cnt_d;
        crc_q <= crc_d;
        bad_q <= bad_d;
        len_q <= len_d;
        chk_q <= chk_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/state_block_header_crc_check.sv -----
// top level: state block header and crc-32 checker with registered handshakes
//
//  channel | dir | payload                                      | request
//  --------+-----+----------------------------------------------+---------------------------
//  in_i    | in  | byte_value[8], last_byte, empty_block        | one block byte
//  out_o   | out | status[2], payload_offset[5], payload_length | one result per block end
//
// one request per cycle sustained unless a block-ending byte waits on a stalled output;
// a block result passes the input register, then crc/header logic into the output register
// the byte-wide crc-32 update plus the length and crc compares set the cycle time
// reset clears the handshake registers and the block state; no clearing pass
// a stalled output holds its result while the input register keeps accepting bytes
// that produce no result; a block-ending byte waits in the input register
`default_nettype none

module state_block_header_crc_check #(
  parameter int unsigned MAX_PAYLOAD = shcc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  shcc_in_if.sink    in_i,
  shcc_out_if.source out_o
);
  import shcc_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_empty_q;

  // output register
  logic                out_vld_q;
  shcc_status_e        out_status_q;
  logic [OFFSET_W-1:0] out_offset_q;
  logic [LEN_W-1:0]    out_length_q;

  shcc_res_t res;
  logic      out_free;
  logic      stage_go;
  logic      in_take;

  // the held byte moves on when it makes no result or the output slot frees up
  assign out_free = !out_vld_q || out_o.ready;
  assign stage_go = in_vld_q && (out_free || !res.valid);
  assign in_take  = in_i.valid && in_i.ready;

  assign in_i.ready = !in_vld_q || stage_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (stage_go) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= in_i.byte_value;
      in_last_q  <= in_i.last_byte;
      in_empty_q <= in_i.empty_block;
    end
  end

  shcc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (stage_go),
    .byte_value_i  (in_byte_q),
    .last_byte_i   (in_last_q),
    .empty_block_i (in_empty_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stage_go && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && res.valid) begin
      out_status_q <= res.status;
      out_offset_q <= res.offset;
      out_length_q <= res.length;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.status         = out_status_q;
  assign out_o.payload_offset = out_offset_q;
  assign out_o.payload_length = out_length_q;

  // a pending result is never dropped by a new block end
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> (out_vld_q && $stable(out_length_q)))
    else $error("pending result overwritten");

  // a held byte that cannot move blocks the input
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !stage_go) |-> !in_i.ready)
    else $error("input accepted while held byte is stuck");

  // valid results carry the header offset and a nonzero length
  a_valid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ST_VALID) |->
      (out_offset_q == OFFSET_W'(HDR_BYTES) && out_length_q != '0))
    else $error("valid result with bad offset or length");

  // empty and invalid results carry zero fields
  a_other_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != ST_VALID) |->
      (out_offset_q == '0 && out_length_q == '0))
    else $error("non-valid result with nonzero fields");

endmodule

`default_nettype wire

// ----- tb/state_block_header_crc_check_checker.sv -----
// checker for the state block header crc checker: predicts block verdicts and compares results
module state_block_header_crc_check_checker #(
  parameter int unsigned MAX_PAYLOAD = shcc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  shcc_in_if          req_i,
  shcc_out_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned valid_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import shcc_pkg::*;

  localparam int unsigned HEADER_LEN = 20;
  localparam logic [31:0] CRC32_POLY = 32'hedb88320;
  localparam logic [7:0]  MAGIC [4]  = '{8'h54, 8'h4d, 8'h52, 8'h41};

  typedef struct packed {
    shcc_status_e        status;
    logic [OFFSET_W-1:0] offset;
    logic [LEN_W-1:0]    length;
  } block_verdict_t;

  block_verdict_t verdict_q[$];

  // running state of the block being received
  logic [31:0] seen_cnt;
  logic [31:0] crc_reg;
  logic [31:0] len_word;
  logic [31:0] crc_word;
  logic        hdr_err;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ CRC32_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // fixed part of the header: magic, version 1, reserved zero
  function automatic logic [7:0] fixed_hdr_byte(input logic [3:0] pos);
    logic [7:0] b;
    if (pos < 4) b = MAGIC[pos[1:0]];
    else if (pos == 4) b = 8'h01;
    else b = 8'h00;
    return b;
  endfunction

  task automatic restart();
    seen_cnt = '0;
    crc_reg  = '1;
    len_word = '0;
    crc_word = '0;
    hdr_err  = 1'b0;
  endtask

  task automatic absorb(input logic [7:0] b);
    if (seen_cnt < 12) begin
      if (b != fixed_hdr_byte(seen_cnt[3:0])) hdr_err = 1'b1;
    end else if (seen_cnt < 16) begin
      len_word |= {24'd0, b} << (8 * seen_cnt[1:0]);
    end else if (seen_cnt < HEADER_LEN) begin
      crc_word |= {24'd0, b} << (8 * seen_cnt[1:0]);
    end else begin
      crc_reg = crc32_step(crc_reg, b);
    end
    if (seen_cnt != '1) seen_cnt++;
  endtask

  function automatic block_verdict_t judge();
    block_verdict_t v;
    bit fits;
    fits = !hdr_err && seen_cnt >= HEADER_LEN && len_word >= 1 && len_word <= MAX_PAYLOAD
        && len_word == seen_cnt - HEADER_LEN && ~crc_reg == crc_word;
    if (fits) begin
      v.status = ST_VALID;
      v.offset = OFFSET_W'(HEADER_LEN);
      v.length = len_word[LEN_W-1:0];
    end else begin
      v.status = ST_INVALID;
      v.offset = '0;
      v.length = '0;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d %s: got 0x%0h, expected 0x%0h",
             $time, checked_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    block_verdict_t want;
    if (!rst_ni) begin
      restart();
      verdict_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      valid_seen_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        if (req_i.empty_block) begin
          want.status = ST_EMPTY;
          want.offset = '0;
          want.length = '0;
          verdict_q.push_back(want);
          restart();
        end else begin
          absorb(req_i.byte_value);
          if (req_i.last_byte) begin
            verdict_q.push_back(judge());
            restart();
          end
        end
      end
      if (res_i.valid && res_i.ready) begin
        checked_o++;
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected, status", res_i.status, '0);
        end else begin
          want = verdict_q.pop_front();
          if (res_i.status !== want.status)
            report_mismatch("status", res_i.status, want.status);
          if (res_i.payload_offset !== want.offset)
            report_mismatch("payload_offset", res_i.payload_offset, want.offset);
          if (res_i.payload_length !== want.length)
            report_mismatch("payload_length", res_i.payload_length, want.length);
          if (want.status == ST_VALID) valid_seen_o++;
        end
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

// ----- tb/state_block_header_crc_check_tb.sv -----
// testbench top: block stimulus, output pacing and verdict for the state block header crc checker
module state_block_header_crc_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shcc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 800;     // random bytes to send, roughly
  localparam int unsigned MIN_RESULTS  = 40;      // keep going until this many block ends
  localparam int unsigned HOLD_CYCLES  = 200;     // long output hold-off
  localparam int unsigned DRAIN_CYCLES = 8;       // settle time after the last verdict is back
  localparam int unsigned CYCLE_LIMIT  = 400000;  // far above the slowest correct run
  localparam logic [7:0]  MAGIC [4]    = '{8'h54, 8'h4d, 8'h52, 8'h41};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  shcc_in_if  in_if ();
  shcc_out_if out_if ();

  // bookkeeping shared by the stimulus and output pacing
  int unsigned items_sent;
  int unsigned results_due;
  bit          hold_req;   // ask the output side for one long hold-off
  bit          burst;      // sender offers back to back
  bit          quiet;      // neither side idles
  logic [7:0]  frame_q[$]; // block currently being built

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned valid_seen;

  state_block_header_crc_check u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  state_block_header_crc_check_checker u_verdict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (in_if),
    .res_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .valid_seen_o (valid_seen)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // payload size: mostly tiny so blocks end often, now and then a few hundred bytes
  function automatic int unsigned pick_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 60);
    return $urandom_range(61, 260);
  endfunction

  // encode a block: header with the given length word, random payload, stored crc
  task automatic build_frame(input int unsigned n_pay, input logic [31:0] len_word,
                             input bit crc_ok);
    logic [7:0]  pay[$];
    logic [31:0] crc;
    logic [7:0]  d;
    crc = '1;
    for (int unsigned i = 0; i < n_pay; i++) begin
      d = 8'($urandom_range(0, 255));
      pay.push_back(d);
      for (int k = 0; k < 8; k++) crc = (crc[0] ^ d[k]) ? ((crc >> 1) ^ 32'hedb88320) : (crc >> 1);
    end
    crc = ~crc;
    // any nonzero flip makes the stored crc wrong
    if (!crc_ok) crc = crc ^ ($urandom() | 32'h1);
    frame_q = {MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3],
               8'h01, 8'h00, 8'h00, 8'h00,   // version word, little-endian
               8'h00, 8'h00, 8'h00, 8'h00};  // reserved word
    for (int s = 0; s < 32; s += 8) frame_q.push_back(len_word[s +: 8]);
    for (int s = 0; s < 32; s += 8) frame_q.push_back(crc[s +: 8]);
    frame_q = {frame_q, pay};
  endtask

  // one request on the input channel; called and returns at a falling edge
  task automatic drive_item(input logic [7:0] b, input logic last, input logic empty);
    int unsigned gap;
    gap = 0;
    if (!burst && !quiet && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.byte_value  <= b;
    in_if.last_byte   <= last;
    in_if.empty_block <= empty;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (empty || last) results_due++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) drive_item(frame_q[i], i == frame_q.size() - 1, 1'b0);
  endtask

  // output side: random stalls, one long hold-off on request, none while quiet
  initial begin : res_pacer
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_left   = idle_len() - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned round;
    int unsigned n;
    int unsigned cut;
    logic [31:0] lw;

    in_if.valid       = 1'b0;
    in_if.byte_value  = 8'h00;
    in_if.last_byte   = 1'b0;
    in_if.empty_block = 1'b0;
    items_sent  = 0;
    results_due = 0;
    hold_req    = 1'b0;
    burst       = 1'b0;
    quiet       = 1'b0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty block with the ignored fields high
    drive_item(8'hff, 1'b1, 1'b1);
    // short block, ends inside the magic
    drive_item(MAGIC[0], 1'b0, 1'b0);
    drive_item(MAGIC[1], 1'b0, 1'b0);
    drive_item(8'h00, 1'b1, 1'b0);
    // smallest valid block: one payload byte
    build_frame(1, 1, 1'b1);
    send_frame();
    // partial block thrown away by an empty block
    drive_item(MAGIC[0], 1'b0, 1'b0);
    drive_item(MAGIC[1], 1'b0, 1'b0);
    drive_item(8'h00, 1'b0, 1'b1);

    // random blocks, mostly well formed
    round = 0;
    while (items_sent < ITEM_TARGET || results_due < MIN_RESULTS) begin
      round++;
      if (round == 6) begin
        // long output hold while the sender keeps offering: the block fills and stalls
        hold_req = 1'b1;
        burst    = 1'b1;
        repeat (5) begin
          n = $urandom_range(1, 3);
          build_frame(n, n, 1'b1);
          send_frame();
        end
        burst = 1'b0;
      end
      if (round == 14) begin
        // sender pause until every block verdict is back
        in_if.valid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      quiet = (round >= 20 && round < 26);

      case ($urandom_range(0, 99)) inside
        [0:57]: begin
          n = pick_payload();
          build_frame(n, n, 1'b1);
          send_frame();
        end
        [58:65]: begin
          // one damaged byte anywhere: magic, version, reserved, length, crc or payload
          n = pick_payload();
          build_frame(n, n, 1'b1);
          cut = $urandom_range(0, frame_q.size() - 1);
          frame_q[cut] ^= 8'($urandom_range(1, 255));
          send_frame();
        end
        [66:71]: begin
          // length word at its limits or off by one
          n = pick_payload();
          case ($urandom_range(0, 5))
            0: begin
              if ($urandom_range(0, 1) == 1) n = 0;
              lw = '0;
            end
            1: lw = MAX_PAYLOAD_DEF;
            2: lw = MAX_PAYLOAD_DEF + 1;
            3: lw = '1;
            4: lw = n + 1;
            default: lw = n - 1;
          endcase
          build_frame(n, lw, 1'b1);
          send_frame();
        end
        [72:75]: begin
          n = pick_payload();
          build_frame(n, n, 1'b0);
          send_frame();
        end
        [76:81]: begin
          // block cut short inside the header
          build_frame(1, 1, 1'b1);
          cut = $urandom_range(1, 19);
          while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
          send_frame();
        end
        [82:86]: begin
          // block abandoned part way by an empty block
          n = pick_payload();
          build_frame(n, n, 1'b1);
          cut = $urandom_range(1, frame_q.size() - 1);
          for (int unsigned i = 0; i < cut; i++) drive_item(frame_q[i], 1'b0, 1'b0);
          drive_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        [87:91]: begin
          drive_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end
        default: begin
          // noise with scattered block ends
          n = $urandom_range(1, 40);
          for (int unsigned i = 0; i < n; i++)
            drive_item(8'($urandom_range(0, 255)),
                       i == n - 1 || $urandom_range(0, 15) == 0, 1'b0);
        end
      endcase
    end
    quiet = 1'b0;
    in_if.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("summary: %0d bytes sent, %0d block verdicts checked, %0d of them valid",
             items_sent, checked, valid_seen);
    $display("summary: empty, short, damaged, mis-sized and abandoned blocks, "
             , "a %0d-cycle output hold and a full drain", HOLD_CYCLES);
    if (fail_count == 0 && checked == results_due) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- state_block_header_crc_check.f -----
sv/shcc_pkg.sv
sv/shcc_in_if.sv
sv/shcc_out_if.sv
sv/shcc_core.sv
sv/state_block_header_crc_check.sv
tb/state_block_header_crc_check_checker.sv
tb/state_block_header_crc_check_tb.sv
